### hdl/gcp_pkg.sv
// Shared types and constants for the GIF code packer with data sub-blocks.
`default_nettype none
package gcp_pkg;

	localparam int CODE_W = 12;
	localparam int CB_W = 4;
	localparam int BYTE_W = 8;
	localparam int WORD_BYTES = 8;
	localparam int WORD_W = BYTE_W * WORD_BYTES;
	localparam int CNT_W = 4;
	localparam int ACC_KEEP_W = 7;
	localparam int BC_W = 3;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_FLUSH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STORE,
		ST_DLEN,
		ST_DRD,
		ST_DEMIT,
		ST_ZERO,
		ST_FIN
	} state_t;

	// byte stream request from the sequencer to the word packer
	typedef struct packed {
		logic              push;
		logic              fin;
		logic [BYTE_W-1:0] data;
	} byte_req_t;

	typedef struct packed {
		logic byte_rdy;
		logic fin_rdy;
	} pk_rdy_t;

endpackage
`default_nettype wire

### hdl/gcp_packer.sv
// Packs the output byte stream into 64-bit little-endian words with a last marker.
`default_nettype none
module gcp_packer (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire gcp_pkg::byte_req_t          req,
	output gcp_pkg::pk_rdy_t                 rdy,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [gcp_pkg::WORD_W-1:0]       out_bytes,
	output logic [gcp_pkg::CNT_W-1:0]        byte_count,
	output logic                             last
);

	localparam logic [gcp_pkg::CNT_W-1:0] FULL = gcp_pkg::CNT_W'(gcp_pkg::WORD_BYTES);

	logic [gcp_pkg::WORD_W-1:0] word_q;
	logic [gcp_pkg::CNT_W-1:0]  cnt_q;
	logic                       ovalid_q;
	logic [gcp_pkg::WORD_W-1:0] obytes_q;
	logic [gcp_pkg::CNT_W-1:0]  ocnt_q;
	logic                       olast_q;
	logic                       out_free;
	logic                       load_out;

	assign out_free     = !ovalid_q || !out_stall;
	assign rdy.byte_rdy = (cnt_q != FULL) || out_free;
	assign rdy.fin_rdy  = (cnt_q == '0) || out_free;
	assign load_out     = (req.push && rdy.byte_rdy && (cnt_q == FULL)) ||
		(req.fin && rdy.fin_rdy && (cnt_q != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q   <= '0;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (ovalid_q && !out_stall) begin
				ovalid_q <= 1'b0;
			end
			if (req.push && rdy.byte_rdy) begin
				if (cnt_q == FULL) begin
					word_q   <= gcp_pkg::WORD_W'(req.data);
					cnt_q    <= gcp_pkg::CNT_W'(1);
				end else begin
					word_q[{cnt_q[2:0], 3'b000} +: gcp_pkg::BYTE_W] <= req.data;
					cnt_q <= cnt_q + 1'b1;
				end
			end else if (req.fin && rdy.fin_rdy && (cnt_q != '0)) begin
				word_q   <= '0;
				cnt_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.push && rdy.byte_rdy && (cnt_q == FULL)) begin
			obytes_q <= word_q;
			ocnt_q   <= cnt_q;
			olast_q  <= 1'b0;
		end else if (req.fin && rdy.fin_rdy && (cnt_q != '0)) begin
			obytes_q <= word_q;
			ocnt_q   <= cnt_q;
			olast_q  <= 1'b1;
		end
	end

	assign out_valid  = ovalid_q;
	assign out_bytes  = obytes_q;
	assign byte_count = ocnt_q;
	assign last       = olast_q;

endmodule
`default_nettype wire

### hdl/gif_code_packer_subblocks_top.sv
// Top level: bit accumulator, sub-block store memory and drain sequencer.
`default_nettype none
// A write request stores each whole byte that it forms; codes that form no
// byte only update the bit accumulator.
// Each byte goes into the block memory (one write port, one registered read
// port). When the block fills, or on a flush, the block is drained: the length
// byte, a memory read, then one stored byte a cycle while the packer takes
// bytes, then a close of the last output word; no request is taken meanwhile.
// A flush also emits a zero terminator byte. Output words carry up to eight
// bytes, first byte in bits 7:0; last marks the final word of a request.
// Output stalls hold the sequencer only when a full word, or the last word at
// its close, waits for the output register. No clearing pass runs after reset.
module gif_code_packer_subblocks_top #(
	parameter int BLOCK_BYTES   = 255,
	parameter int MAX_CODE_BITS = 12
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              func,
	input  wire logic [gcp_pkg::CODE_W-1:0]        code,
	input  wire logic [gcp_pkg::CB_W-1:0]          code_bits,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [gcp_pkg::WORD_W-1:0]             out_bytes,
	output logic [gcp_pkg::CNT_W-1:0]              byte_count,
	output logic                                   last
);

	localparam int AW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
	localparam int FW = $clog2(BLOCK_BYTES + 1);
	localparam int CBE_W = 5;
	localparam int EFF_W = (MAX_CODE_BITS > gcp_pkg::CODE_W) ? MAX_CODE_BITS : gcp_pkg::CODE_W;
	localparam int ACC_W = gcp_pkg::ACC_KEEP_W + EFF_W;
	localparam logic [FW-1:0] FILL_MAX = FW'(BLOCK_BYTES);
	localparam logic [CBE_W-1:0] CB_MAX = CBE_W'(MAX_CODE_BITS);

	gcp_pkg::state_t state_q, state_d;

	logic [gcp_pkg::ACC_KEEP_W-1:0] acc_q;
	logic [gcp_pkg::BC_W-1:0]       bc_q;
	logic [FW-1:0]                  fill_q;
	logic [1:0]                     nb_q;
	logic                           flush_q;
	logic                           drained_q;
	logic [2*gcp_pkg::BYTE_W-1:0]   b_q;
	logic [AW-1:0]                  idx_q;
	logic [gcp_pkg::BYTE_W-1:0]     rd_data_q;

	logic [gcp_pkg::BYTE_W-1:0] mem [BLOCK_BYTES];

	gcp_pkg::byte_req_t pk_req;
	gcp_pkg::pk_rdy_t   pk_rdy;

	logic                       accept;
	logic [CBE_W-1:0]           cbm;
	logic [gcp_pkg::CODE_W-1:0] code_m;
	logic [ACC_W-1:0]           acc_w;
	logic [ACC_W-1:0]           acc_sh;
	logic [CBE_W-1:0]           n_w;
	logic [FW-1:0]              fill_inc;
	logic                       last_rd;
	logic                       mem_we;
	logic                       mem_re;
	logic [AW-1:0]              mem_raddr;

	assign accept = in_valid && !in_stall;

	// code merge
	always_comb begin
		cbm    = ({1'b0, code_bits} > CB_MAX) ? CB_MAX : {1'b0, code_bits};
		code_m = code & ~({gcp_pkg::CODE_W{1'b1}} << cbm);
		acc_w  = ACC_W'(acc_q) | (ACC_W'(code_m) << bc_q);
		n_w    = CBE_W'(bc_q) + cbm;
		acc_sh = acc_w >> {n_w[4:3], 3'b000};
	end

	assign fill_inc = fill_q + 1'b1;
	assign last_rd  = (FW'(idx_q) + 1'b1) == fill_q;

	always_comb begin
		state_d     = state_q;
		in_stall    = (state_q != gcp_pkg::ST_IDLE);
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		mem_raddr   = idx_q;
		pk_req      = '0;
		unique case (state_q)
			gcp_pkg::ST_IDLE: begin
				if (accept) begin
					if (func == gcp_pkg::FUNC_FLUSH) begin
						if (bc_q != '0) begin
							state_d = gcp_pkg::ST_STORE;
						end else if (fill_q != '0) begin
							state_d = gcp_pkg::ST_DLEN;
						end else begin
							state_d = gcp_pkg::ST_ZERO;
						end
					end else if (n_w[4:3] != 2'd0) begin
						state_d = gcp_pkg::ST_STORE;
					end
				end
			end
			gcp_pkg::ST_STORE: begin
				mem_we = 1'b1;
				priority if (fill_inc == FILL_MAX) begin
					state_d = gcp_pkg::ST_DLEN;
				end else if (nb_q != 2'd1) begin
					state_d = gcp_pkg::ST_STORE;
				end else if (flush_q) begin
					state_d = gcp_pkg::ST_DLEN;
				end else if (drained_q) begin
					state_d = gcp_pkg::ST_FIN;
				end else begin
					state_d = gcp_pkg::ST_IDLE;
				end
			end
			gcp_pkg::ST_DLEN: begin
				pk_req.push = 1'b1;
				pk_req.data = gcp_pkg::BYTE_W'(fill_q);
				if (pk_rdy.byte_rdy) begin
					state_d = gcp_pkg::ST_DRD;
				end
			end
			gcp_pkg::ST_DRD: begin
				mem_re  = 1'b1;
				state_d = gcp_pkg::ST_DEMIT;
			end
			gcp_pkg::ST_DEMIT: begin
				pk_req.push = 1'b1;
				pk_req.data = rd_data_q;
				if (pk_rdy.byte_rdy) begin
					if (last_rd) begin
						priority if (nb_q != 2'd0) begin
							state_d = gcp_pkg::ST_STORE;
						end else if (flush_q) begin
							state_d = gcp_pkg::ST_ZERO;
						end else begin
							state_d = gcp_pkg::ST_FIN;
						end
					end else begin
						mem_re    = 1'b1;
						mem_raddr = idx_q + 1'b1;
					end
				end
			end
			gcp_pkg::ST_ZERO: begin
				pk_req.push = 1'b1;
				pk_req.data = '0;
				if (pk_rdy.byte_rdy) begin
					state_d = gcp_pkg::ST_FIN;
				end
			end
			gcp_pkg::ST_FIN: begin
				pk_req.fin = 1'b1;
				if (pk_rdy.fin_rdy) begin
					state_d = gcp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gcp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			bc_q      <= '0;
			fill_q    <= '0;
			nb_q      <= '0;
			flush_q   <= 1'b0;
			drained_q <= 1'b0;
		end else begin
			unique case (state_q)
				gcp_pkg::ST_IDLE: begin
					if (accept) begin
						flush_q   <= (func == gcp_pkg::FUNC_FLUSH);
						drained_q <= 1'b0;
						if (func == gcp_pkg::FUNC_FLUSH) begin
							nb_q  <= {1'b0, bc_q != '0};
							acc_q <= '0;
							bc_q  <= '0;
						end else begin
							nb_q  <= n_w[4:3];
							acc_q <= acc_sh[gcp_pkg::ACC_KEEP_W-1:0];
							bc_q  <= n_w[2:0];
						end
					end
				end
				gcp_pkg::ST_STORE: begin
					fill_q <= fill_inc;
					nb_q   <= nb_q - 1'b1;
				end
				gcp_pkg::ST_DLEN: begin
					if (pk_rdy.byte_rdy) begin
						drained_q <= 1'b1;
					end
				end
				gcp_pkg::ST_DEMIT: begin
					if (pk_rdy.byte_rdy && last_rd) begin
						fill_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == gcp_pkg::ST_IDLE && accept) begin
			b_q <= (func == gcp_pkg::FUNC_FLUSH) ? (2*gcp_pkg::BYTE_W)'(acc_q)
				: acc_w[2*gcp_pkg::BYTE_W-1:0];
		end else if (state_q == gcp_pkg::ST_STORE) begin
			b_q <= b_q >> gcp_pkg::BYTE_W;
		end
		if (state_q == gcp_pkg::ST_DLEN) begin
			idx_q <= '0;
		end else if (state_q == gcp_pkg::ST_DEMIT && pk_rdy.byte_rdy && !last_rd) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// block store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[fill_q[AW-1:0]] <= b_q[gcp_pkg::BYTE_W-1:0];
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	gcp_packer u_packer (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (pk_req),
		.rdy        (pk_rdy),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_bytes  (out_bytes),
		.byte_count (byte_count),
		.last       (last)
	);

`ifndef NO_ASSERTIONS
	a_flush_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (func == gcp_pkg::FUNC_FLUSH) |=> state_q != gcp_pkg::ST_IDLE)
		else $error("flush request produced no output sequence");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gcp_pkg::ST_IDLE |-> fill_q < FILL_MAX)
		else $error("block store left full while idle");

	a_acc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gcp_pkg::ST_IDLE |-> (acc_q >> bc_q) == '0)
		else $error("accumulator holds bits above the pending count");

	a_fin_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pk_req.fin |-> drained_q || flush_q)
		else $error("word close without any emitted bytes");
`endif

endmodule
`default_nettype wire
